// ----- src/mbp_pkg.sv -----
// Shared types and constants of the MSB-first bit packer.
package mbp_pkg;

  localparam int OCTET_W      = 8;
  localparam int CLOSE_BITS   = 7;
  localparam int BIT_DATA_W   = 64;
  localparam int BIT_COUNT_W  = 7;
  localparam int REQ_W        = 2;
  localparam int IN_TDATA_W   = 72;
  localparam int OUT_TDATA_W  = 112;
  localparam int APB_ADDR_W   = 2;
  localparam int APB_DATA_W   = 32;

  // Request codes on the input tuser
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLOSE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Register addresses
  localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = 2'd0;

  // Command kinds passed from front to back
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_kind_t;

  // One result transaction, first field in the highest bits
  typedef struct packed {
    logic [31:0] total_bytes;
    logic [31:0] total_bits;
    logic        overflow;
    logic [31:0] octet_index;
    logic [7:0]  octet;
  } result_t;

endpackage

// ----- src/mbp_front.sv -----
// Front end: accept input transactions and turn them into back-end commands.
module mbp_front #(
  parameter int DW = 64,
  parameter int CW = 7
) (
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mbp_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic [mbp_pkg::REQ_W-1:0]           s_tuser,
  input  logic                                q_full,
  output logic                                push,
  output mbp_pkg::cmd_kind_t                  cmd_kind,
  output logic [CW-1:0]                       cmd_count,
  output logic [DW-1:0]                       cmd_data
);

  logic [mbp_pkg::BIT_DATA_W-1:0]  bit_data;
  logic [mbp_pkg::BIT_COUNT_W-1:0] bit_count;
  logic                            keep;

  assign bit_data  = s_tdata[mbp_pkg::BIT_DATA_W-1:0];
  assign bit_count = s_tdata[mbp_pkg::BIT_DATA_W +: mbp_pkg::BIT_COUNT_W];

  always_comb begin
    keep      = 1'b0;
    cmd_kind  = mbp_pkg::CMD_WRITE;
    cmd_count = '0;
    cmd_data  = '0;
    unique case (s_tuser)
      mbp_pkg::REQ_WRITE: begin
        // drop empty writes, saturate long ones
        keep     = (bit_count != '0);
        cmd_data = bit_data[DW-1:0];
        if (bit_count > mbp_pkg::BIT_COUNT_W'(DW)) begin
          cmd_count = CW'(DW);
        end else begin
          cmd_count = CW'(bit_count);
        end
      end
      mbp_pkg::REQ_CLOSE: begin
        keep      = 1'b1;
        cmd_count = CW'(mbp_pkg::CLOSE_BITS);
      end
      mbp_pkg::REQ_CLEAR: begin
        keep     = 1'b1;
        cmd_kind = mbp_pkg::CMD_CLEAR;
      end
      default: keep = 1'b0;
    endcase
  end

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready && keep;

endmodule

// ----- src/mbp_fifo.sv -----
// Two-entry command queue between front and back.
module mbp_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         q_valid,
  output logic         q_full
);

  logic [W-1:0] entry [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign rdata   = entry[rptr];
  assign q_valid = (count != 2'd0);
  assign q_full  = (count == 2'd2);

endmodule

// ----- src/mbp_back.sv -----
// Back end: merge commands into the pending byte and emit completed octets.
module mbp_back #(
  parameter int DW = 64,
  parameter int CW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [31:0]          capacity,
  input  logic                 q_valid,
  input  mbp_pkg::cmd_kind_t   q_kind,
  input  logic [CW-1:0]        q_count,
  input  logic [DW-1:0]        q_data,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output mbp_pkg::result_t     m_result,
  output logic                 m_last
);

  localparam int AW = DW + mbp_pkg::OCTET_W;
  localparam int RW = $clog2(AW);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t        state, state_next;
  logic [7:0]    pend, pend_next;      // left aligned partial byte
  logic [2:0]    pc, pc_next;
  logic [31:0]   bit_total, bit_total_next;
  logic [31:0]   byte_total, byte_total_next;
  logic [AW-1:0] acc, acc_next;        // left aligned bits still to emit
  logic [RW-1:0] rem, rem_next;

  logic [DW-1:0] data_left;
  logic [AW-1:0] acc_load;
  logic [RW-1:0] rem_load;
  logic [RW-1:0] rem_minus8;
  logic          rem_last;
  logic          full;
  logic          out_load;

  assign data_left  = q_data << (CW'(DW) - q_count);
  assign acc_load   = {pend, {DW{1'b0}}} | ({data_left, 8'h00} >> pc);
  assign rem_load   = RW'(pc) + RW'(q_count);
  assign rem_minus8 = rem - RW'(mbp_pkg::OCTET_W);
  assign rem_last   = rem_minus8 < RW'(mbp_pkg::OCTET_W);
  assign full       = byte_total >= capacity;

  always_comb begin
    state_next      = state;
    pend_next       = pend;
    pc_next         = pc;
    bit_total_next  = bit_total;
    byte_total_next = byte_total;
    acc_next        = acc;
    rem_next        = rem;
    pop             = 1'b0;
    out_load        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_kind == mbp_pkg::CMD_CLEAR) begin
            pend_next       = '0;
            pc_next         = '0;
            bit_total_next  = '0;
            byte_total_next = '0;
          end else begin
            acc_next       = acc_load;
            rem_next       = rem_load;
            bit_total_next = bit_total + 32'(q_count);
            if (rem_load >= RW'(mbp_pkg::OCTET_W)) begin
              state_next = ST_EMIT;
            end else begin
              pend_next = acc_load[AW-1 -: 8];
              pc_next   = rem_load[2:0];
            end
          end
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          acc_next = acc << mbp_pkg::OCTET_W;
          rem_next = rem_minus8;
          if (!full) begin
            byte_total_next = byte_total + 32'd1;
          end
          if (rem_last) begin
            state_next = ST_IDLE;
            pend_next  = acc[DW-1 -: 8];
            pc_next    = rem_minus8[2:0];
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend       <= '0;
      pc         <= '0;
      bit_total  <= '0;
      byte_total <= '0;
      rem        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      pend       <= pend_next;
      pc         <= pc_next;
      bit_total  <= bit_total_next;
      byte_total <= byte_total_next;
      rem        <= rem_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (out_load) begin
      m_result.octet       <= acc[AW-1 -: 8];
      m_result.octet_index <= byte_total;
      m_result.overflow    <= full;
      m_result.total_bits  <= bit_total;
      m_result.total_bytes <= byte_total_next;
      m_last               <= rem_last;
    end
  end

  a_emit_has_octet: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> rem >= RW'(mbp_pkg::OCTET_W))
    else $error("emit state without a full octet");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == ST_IDLE)
    else $error("command popped while emitting");

  a_overflow_holds_count: assert property (@(posedge clk) disable iff (rst)
    $past(out_load) && m_result.overflow |-> m_result.total_bytes == m_result.octet_index)
    else $error("byte count advanced on overflow");

  a_count_advances: assert property (@(posedge clk) disable iff (rst)
    $past(out_load) && !m_result.overflow
      |-> m_result.total_bytes == m_result.octet_index + 32'd1)
    else $error("byte count did not advance");

endmodule

// ----- src/msb_first_bit_packer.sv -----
// Top level: MSB-first bit packer with stream ports and an APB register port.
// An input transaction is queued and taken by the back end when idle; its first octet
//   is registered onto m_tvalid from the back end's emit state.
// A transaction that completes no octet leaves the back end idle for the next; one that
//   completes k octets (k up to 8) emits them one per cycle unless the output stalls.
// Reset clears all packing state, the command queue and buffer_capacity; no clearing pass.
module msb_first_bit_packer #(
  parameter int MAX_WRITE_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // stream input
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mbp_pkg::IN_TDATA_W-1:0]      s_tdata,  // bit_data[63:0], bit_count[70:64]
  input  logic [mbp_pkg::REQ_W-1:0]           s_tuser,  // req_type[1:0]
  // stream output
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // octet[7:0], octet_index[39:8], overflow[40], total_bits[72:41], total_bytes[104:73]
  output logic [mbp_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                m_tlast,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mbp_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [mbp_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [mbp_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int DW = MAX_WRITE_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam int QW = 1 + CW + DW;

  logic [31:0]         capacity;

  logic                push;
  mbp_pkg::cmd_kind_t  f_kind;
  logic [CW-1:0]       f_count;
  logic [DW-1:0]       f_data;

  logic [QW-1:0]       q_rdata;
  logic                q_valid;
  logic                q_full;
  logic                pop;

  mbp_pkg::result_t    result;

  // Buffer capacity register; the only register, at byte address 0
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr == mbp_pkg::ADDR_CAPACITY) begin
      capacity <= pwdata;
    end
  end

  assign prdata = (paddr == mbp_pkg::ADDR_CAPACITY) ? capacity : '0;

  // Front: classify requests, drop unknown and empty ones, saturate length
  mbp_front #(.DW(DW), .CW(CW)) u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .push      (push),
    .cmd_kind  (f_kind),
    .cmd_count (f_count),
    .cmd_data  (f_data)
  );

  // Short command queue so input and output stall independently
  mbp_fifo #(.W(QW)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wdata   ({f_kind, f_count, f_data}),
    .pop     (pop),
    .rdata   (q_rdata),
    .q_valid (q_valid),
    .q_full  (q_full)
  );

  // Back: merge bits into the pending byte, emit one octet per cycle unless stalled
  mbp_back #(.DW(DW), .CW(CW)) u_back (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .q_valid  (q_valid),
    .q_kind   (mbp_pkg::cmd_kind_t'(q_rdata[QW-1])),
    .q_count  (q_rdata[DW +: CW]),
    .q_data   (q_rdata[DW-1:0]),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_result (result),
    .m_last   (m_tlast)
  );

  // Pad the result to whole bytes
  assign m_tdata = {{(mbp_pkg::OUT_TDATA_W - $bits(mbp_pkg::result_t)){1'b0}}, result};

endmodule

// ----- tb/sv/msb_first_bit_packer_test.sv -----
// Self-checking stream testbench for the MSB-first bit packer.
`timescale 1ns / 100ps

module msb_first_bit_packer_test;

  localparam int MAX_BITS = 64;
  // The request field is two bits wide; the one code the block does not define
  localparam logic [mbp_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int SETTLE_CYCLES = 4;  // in-flight time of an item that emits nothing
  localparam int FINAL_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [mbp_pkg::REQ_W-1:0]       req;
    logic [mbp_pkg::BIT_DATA_W-1:0]  data;
    logic [mbp_pkg::BIT_COUNT_W-1:0] count;
  } bit_group_t;

  typedef struct {
    mbp_pkg::result_t res;
    bit               last;
  } octet_due_t;

  // Clock, reset and every block input start at known values
  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  // bit_data[63:0], bit_count[70:64]
  logic [mbp_pkg::IN_TDATA_W-1:0]     s_tdata = '0;
  logic [mbp_pkg::REQ_W-1:0]          s_tuser = '0;   // req_type[1:0]
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  // octet[7:0], octet_index[39:8], overflow[40], total_bits[72:41], total_bytes[104:73]
  logic [mbp_pkg::OUT_TDATA_W-1:0]    m_tdata;
  logic                               m_tlast;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [mbp_pkg::APB_ADDR_W-1:0]     paddr = '0;
  logic [mbp_pkg::APB_DATA_W-1:0]     pwdata = '0;
  logic [mbp_pkg::APB_DATA_W-1:0]     prdata;
  logic                               pready;

  msb_first_bit_packer #(
    .MAX_WRITE_BITS(MAX_BITS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Bit groups waiting for the driver, and octets the packer still owes us
  bit_group_t groups_to_send[$];
  octet_due_t octets_due[$];

  // Packer state as the predictor sees it
  logic [31:0] capacity_cfg = '0;
  logic [7:0]  pend_byte = '0;
  int          pend_cnt = 0;
  logic [31:0] bit_sum = '0;
  logic [31:0] byte_sum = '0;

  // Bookkeeping
  int  groups_queued = 0;
  int  groups_taken = 0;
  int  octets_checked = 0;
  int  overflows_seen = 0;
  int  settings_used = 0;
  int  mismatches = 0;
  bit  in_fire = 1'b0;
  bit  out_fire = 1'b0;
  int  src_gap = 0;
  int  sink_wait = 0;
  bit  src_burst = 1'b0;
  bit  sink_burst = 1'b0;
  bit_group_t next_group;

  initial forever #5 clk = ~clk;

  // Count a mismatch; only the first few are worth reading
  function automatic void note_mismatch(string what, longint unsigned want,
                                        longint unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch in %s at octet %0d: expected %0h, got %0h",
               what, octets_checked, want, got);
  endfunction

  // Advance the packer state by one accepted transaction and queue the octets it completes
  function automatic void pack_group(logic [mbp_pkg::REQ_W-1:0] req,
                                     logic [mbp_pkg::BIT_DATA_W-1:0] bits,
                                     logic [mbp_pkg::BIT_COUNT_W-1:0] count);
    int unsigned n;
    octet_due_t  o;
    octet_due_t  batch[$];
    n = 0;
    unique case (req)
      mbp_pkg::REQ_WRITE: n = (count > MAX_BITS) ? MAX_BITS : count;  // clamp oversized
      mbp_pkg::REQ_CLOSE: begin
        // seven zero bits flush any partial byte
        n = mbp_pkg::CLOSE_BITS;
        bits = '0;
      end
      mbp_pkg::REQ_CLEAR: begin
        pend_byte = '0;
        pend_cnt = 0;
        bit_sum = '0;
        byte_sum = '0;
      end
      default: n = 0;  // unknown request: no effect
    endcase
    if (n == 0)
      return;
    bit_sum = bit_sum + n;
    for (int k = n - 1; k >= 0; k--) begin
      pend_byte = {pend_byte[6:0], bits[k]};
      pend_cnt++;
      if (pend_cnt == mbp_pkg::OCTET_W) begin
        o.res.octet = pend_byte;
        o.res.octet_index = byte_sum;
        o.res.overflow = (byte_sum >= capacity_cfg);
        // a full buffer still emits the octet but does not count it
        if (!o.res.overflow)
          byte_sum = byte_sum + 1;
        o.res.total_bytes = byte_sum;
        o.res.total_bits = '0;
        o.last = 1'b0;
        batch.push_back(o);
        pend_byte = '0;
        pend_cnt = 0;
      end
    end
    // bit total is the one after the whole group; only the final octet carries last
    foreach (batch[i]) begin
      batch[i].res.total_bits = bit_sum;
      batch[i].last = (i == batch.size() - 1);
      octets_due.push_back(batch[i]);
    end
  endfunction

  function automatic void check_octet(logic [mbp_pkg::OUT_TDATA_W-1:0] bus, logic tlast);
    mbp_pkg::result_t got;
    octet_due_t       want;
    got = bus[$bits(mbp_pkg::result_t)-1:0];
    if (octets_due.size() == 0) begin
      note_mismatch("unexpected octet", 0, got.octet);
      return;
    end
    want = octets_due.pop_front();
    if (got.octet != want.res.octet)
      note_mismatch("octet", want.res.octet, got.octet);
    if (got.octet_index != want.res.octet_index)
      note_mismatch("octet_index", want.res.octet_index, got.octet_index);
    if (got.overflow != want.res.overflow)
      note_mismatch("overflow", want.res.overflow, got.overflow);
    if (got.total_bits != want.res.total_bits)
      note_mismatch("total_bits", want.res.total_bits, got.total_bits);
    if (got.total_bytes != want.res.total_bytes)
      note_mismatch("total_bytes", want.res.total_bytes, got.total_bytes);
    if (tlast != want.last)
      note_mismatch("last", want.last, tlast);
    octets_checked++;
    if (want.res.overflow)
      overflows_seen++;
  endfunction

  // Monitor: sample both handshakes at the rising edge, predict before checking
  always @(posedge clk) begin
    in_fire = !rst && s_tvalid && s_tready;
    out_fire = !rst && m_tvalid && m_tready;
    if (in_fire) begin
      groups_taken++;
      pack_group(s_tuser, s_tdata[mbp_pkg::BIT_DATA_W-1:0],
                 s_tdata[mbp_pkg::BIT_DATA_W+mbp_pkg::BIT_COUNT_W-1:mbp_pkg::BIT_DATA_W]);
    end
    if (out_fire)
      check_octet(m_tdata, m_tlast);
  end

  // Driver: hold the current transaction until taken, then wait its gap and send the next
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (src_gap != 0 || groups_to_send.size() == 0) begin
        if (src_gap != 0)
          src_gap--;
        s_tvalid <= 1'b0;
      end else begin
        next_group = groups_to_send.pop_front();
        s_tdata <= {1'b0, next_group.count, next_group.data};
        s_tuser <= next_group.req;
        s_tvalid <= 1'b1;
        src_gap = src_burst ? 0 : $urandom_range(0, 3);
        // switch now and then between back-to-back and gappy sending
        if ($urandom_range(0, 40) == 0)
          src_burst = !src_burst;
      end
    end
  end

  // Sink: stall a random number of cycles after each accepted octet
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_fire) begin
        sink_wait = sink_burst ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 40) == 0)
          sink_burst = !sink_burst;
      end
      if (sink_wait != 0) begin
        sink_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic void queue_group(logic [mbp_pkg::REQ_W-1:0] req,
                                      logic [mbp_pkg::BIT_DATA_W-1:0] data, int count);
    bit_group_t g;
    g.req = req;
    g.data = data;
    g.count = mbp_pkg::BIT_COUNT_W'(count);
    groups_to_send.push_back(g);
    groups_queued++;
  endfunction

  // Mostly short codewords, some long and oversized writes, a sprinkling of control
  function automatic void queue_random_group();
    int                             pick;
    logic [mbp_pkg::BIT_DATA_W-1:0] data;
    pick = $urandom_range(0, 99);
    data = {$urandom, $urandom};
    if (pick < 55)
      queue_group(mbp_pkg::REQ_WRITE, data, $urandom_range(1, 16));
    else if (pick < 72)
      queue_group(mbp_pkg::REQ_WRITE, data, $urandom_range(17, 64));
    else if (pick < 77)
      queue_group(mbp_pkg::REQ_WRITE, data, $urandom_range(65, 127));
    else if (pick < 80)
      queue_group(mbp_pkg::REQ_WRITE, data, 0);
    else if (pick < 90)
      queue_group(mbp_pkg::REQ_CLOSE, data, $urandom_range(0, 127));
    else if (pick < 94)
      queue_group(mbp_pkg::REQ_CLEAR, data, $urandom_range(0, 127));
    else if (pick < 96)
      queue_group(REQ_UNKNOWN, data, $urandom_range(0, 127));
    else
      queue_group(mbp_pkg::REQ_WRITE, ($urandom_range(0, 1) != 0) ? '1 : '0, MAX_BITS);
  endfunction

  // Hold the sender until everything queued is taken and every octet has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (groups_taken != groups_queued || octets_due.size() != 0);
    // let an item that emits nothing leave the pipeline
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the capacity register, then read it back
  task automatic program_capacity(logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= mbp_pkg::ADDR_CAPACITY;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    capacity_cfg = value;
    settings_used++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== value)
      note_mismatch("capacity readback", value, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random(int count);
    queue_group(mbp_pkg::REQ_CLEAR, '0, 0);  // start each setting from an empty buffer
    repeat (count) queue_random_group();
    wait_idle();
  endtask

  // Main sequence
  initial begin
    int failures;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed part with a buffer that never fills
    program_capacity(32'hFFFF_FFFF);
    queue_group(mbp_pkg::REQ_WRITE, '1, 0);                       // empty write
    queue_group(mbp_pkg::REQ_CLOSE, '1, 7'h7F);                   // close, nothing pending
    queue_group(mbp_pkg::REQ_WRITE, 64'd1, 1);                    // completes first octet
    queue_group(mbp_pkg::REQ_WRITE, '1, MAX_BITS);                // eight octets
    queue_group(mbp_pkg::REQ_WRITE, 64'hA5C3_0F96_7E18_5AF0, MAX_BITS);
    queue_group(mbp_pkg::REQ_WRITE, '1, 7'h7F);                   // oversized, clamps
    queue_group(mbp_pkg::REQ_WRITE, 64'h8000_0000_0000_0001, 65);
    queue_group(mbp_pkg::REQ_WRITE, 64'd5, 3);
    queue_group(mbp_pkg::REQ_CLOSE, '0, 0);                       // flush a partial byte
    queue_group(mbp_pkg::REQ_WRITE, 64'h3F, 6);
    queue_group(mbp_pkg::REQ_WRITE, 64'h00, 8);
    queue_group(mbp_pkg::REQ_WRITE, 64'hFF, 8);
    queue_group(REQ_UNKNOWN, '1, MAX_BITS);                       // ignored
    queue_group(mbp_pkg::REQ_CLEAR, '1, 7'h7F);
    queue_group(mbp_pkg::REQ_WRITE, 64'h55, 7);
    queue_group(mbp_pkg::REQ_WRITE, 64'hFFFF_FFFF_FFFF_FFFE, 1);  // only the low bit counts
    queue_group(mbp_pkg::REQ_WRITE, '0, MAX_BITS);
    queue_group(mbp_pkg::REQ_CLOSE, '0, 0);
    queue_group(mbp_pkg::REQ_CLOSE, '0, 0);
    queue_group(mbp_pkg::REQ_WRITE, '1, 63);
    wait_idle();

    // No room at all: every octet overflows
    program_capacity(32'd0);
    queue_group(mbp_pkg::REQ_CLEAR, '0, 0);
    queue_group(mbp_pkg::REQ_WRITE, 64'hBEEF, 16);
    queue_group(mbp_pkg::REQ_CLOSE, '0, 0);
    run_random(60);

    // Tiny buffer: overflow soon after each clear
    program_capacity(32'd3);
    run_random(70);

    program_capacity($urandom_range(20, 400));
    run_random(90);

    program_capacity(32'hFFFF_FFFF);
    run_random(100);

    // Catch any stray octet after the last expected one
    repeat (FINAL_CYCLES) @(negedge clk);

    failures = mismatches + octets_due.size();
    $display("run: %0d input transactions, %0d octets checked, %0d with overflow",
             groups_taken, octets_checked, overflows_seen);
    $display("run: %0d capacity settings, %0d mismatches", settings_used, mismatches);
    if (failures == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout waiting for the packer");
    $display("tb: failure");
    $finish;
  end

endmodule
